### rtl/core/nec_ir_frame_decoder_top_macros.svh
// Assertion macros used by the NEC IR frame decoder port-level checker.
// Depends on signals named clk and rst in the scope of use.
`ifndef NEC_IR_FRAME_DECODER_TOP_MACROS_SVH
`define NEC_IR_FRAME_DECODER_TOP_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define NECIR_AST_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("necir assertion failed");

// Next-cycle implication, off while reset is high.
`define NECIR_AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("necir assertion failed");

// Next-cycle implication that also runs during reset.
`define NECIR_AST_NEXT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("necir reset assertion failed");

`endif

### rtl/core/necir_pkg.sv
// Package of the NEC IR frame decoder: widths, register indexes, types
// and the duration match function. Depends on nothing.
`default_nettype none

package necir_pkg;

  localparam int MAX_SYMBOLS = 64;
  localparam int IDX_W = $clog2(MAX_SYMBOLS + 1);
  localparam int TICK_W = 15;
  localparam int MARGIN_W = 10;
  localparam int FIELD_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DATA_FRAME_LEN = 34;
  localparam int REPEAT_FRAME_LEN = 2;
  localparam int DATA_BITS = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH_MARGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_MARK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_SPACE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MARK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_SPACE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd7;

  localparam logic [MARGIN_W-1:0] RST_MATCH_MARGIN = 10'd200;
  localparam logic [TICK_W-1:0] RST_LEAD_MARK    = 15'd9000;
  localparam logic [TICK_W-1:0] RST_LEAD_SPACE   = 15'd4500;
  localparam logic [TICK_W-1:0] RST_REPEAT_MARK  = 15'd9000;
  localparam logic [TICK_W-1:0] RST_REPEAT_SPACE = 15'd2250;
  localparam logic [TICK_W-1:0] RST_BIT_MARK     = 15'd560;
  localparam logic [TICK_W-1:0] RST_ZERO_SPACE   = 15'd560;
  localparam logic [TICK_W-1:0] RST_ONE_SPACE    = 15'd1690;

  typedef struct packed {
    logic [MARGIN_W-1:0] match_margin;
    logic [TICK_W-1:0]   lead_mark;
    logic [TICK_W-1:0]   lead_space;
    logic [TICK_W-1:0]   repeat_mark;
    logic [TICK_W-1:0]   repeat_space;
    logic [TICK_W-1:0]   bit_mark;
    logic [TICK_W-1:0]   zero_space;
    logic [TICK_W-1:0]   one_space;
  } cfg_t;

  typedef struct packed {
    logic [TICK_W-1:0] mark_ticks;
    logic [TICK_W-1:0] space_ticks;
    logic              end_of_frame;
  } sym_t;

  typedef struct packed {
    logic lead;
    logic rpt;
    logic one;
    logic zero;
  } match_t;

  // The bounds use one extra bit so neither sum wraps.
  function automatic logic dur_match(input logic [TICK_W-1:0] dur,
                                     input logic [TICK_W-1:0] spec,
                                     input logic [MARGIN_W-1:0] margin);
    logic [TICK_W:0] upper;
    logic [TICK_W:0] reach;
    upper = {1'b0, spec} + {{(TICK_W + 1 - MARGIN_W){1'b0}}, margin};
    reach = {1'b0, dur} + {{(TICK_W + 1 - MARGIN_W){1'b0}}, margin};
    return ({1'b0, dur} < upper) && (reach > {1'b0, spec});
  endfunction

endpackage

`default_nettype wire

### rtl/core/necir_if.sv
// Valid/ready channel interfaces for symbol requests and decoded results.
// Depends on necir_pkg for field widths.
`default_nettype none

interface necir_sym_if;
  logic                        valid;
  logic                        ready;
  logic [necir_pkg::TICK_W-1:0] mark_ticks;
  logic [necir_pkg::TICK_W-1:0] space_ticks;
  logic                        end_of_frame;

  modport source (output valid, output mark_ticks, output space_ticks,
                  output end_of_frame, input ready);
  modport sink (input valid, input mark_ticks, input space_ticks,
                input end_of_frame, output ready);
endinterface

interface necir_res_if;
  logic                         valid;
  logic                         ready;
  logic [necir_pkg::FIELD_W-1:0] ir_address;
  logic [necir_pkg::FIELD_W-1:0] ir_command;
  logic                         is_repeat;

  modport source (output valid, output ir_address, output ir_command,
                  output is_repeat, input ready);
  modport sink (input valid, input ir_address, input ir_command,
                input is_repeat, output ready);
endinterface

`default_nettype wire

### rtl/core/necir_match.sv
// Duration matcher: compares one registered symbol with the configured
// leading, repeat and bit codes. Depends on necir_pkg.
`default_nettype none

module necir_match (
  input  necir_pkg::cfg_t   cfg,
  input  necir_pkg::sym_t   sym,
  output necir_pkg::match_t hit
);
  import necir_pkg::*;

  logic bit_mark_ok;

  assign bit_mark_ok = dur_match(sym.mark_ticks, cfg.bit_mark, cfg.match_margin);

  assign hit.lead = dur_match(sym.mark_ticks, cfg.lead_mark, cfg.match_margin)
                 && dur_match(sym.space_ticks, cfg.lead_space, cfg.match_margin);
  assign hit.rpt  = dur_match(sym.mark_ticks, cfg.repeat_mark, cfg.match_margin)
                 && dur_match(sym.space_ticks, cfg.repeat_space, cfg.match_margin);
  assign hit.one  = bit_mark_ok
                 && dur_match(sym.space_ticks, cfg.one_space, cfg.match_margin);
  assign hit.zero = bit_mark_ok
                 && dur_match(sym.space_ticks, cfg.zero_space, cfg.match_margin);

endmodule

`default_nettype wire

### rtl/core/necir_frame.sv
// Frame tracker: per-frame state, saved address and command, and the
// result register. Depends on necir_pkg, necir_if and necir_match flags.
`default_nettype none

module necir_frame (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  necir_pkg::sym_t   sym,
  input  necir_pkg::match_t hit,
  necir_res_if.source       res
);
  import necir_pkg::*;

  logic [IDX_W-1:0]     symbol_index;
  logic [IDX_W-1:0]     symbol_index_next;
  logic                 lead_ok;
  logic                 lead_ok_next;
  logic                 repeat_ok;
  logic                 repeat_ok_next;
  logic                 bits_ok;
  logic                 bits_ok_next;
  logic [DATA_BITS-1:0] shift_bits;
  logic [DATA_BITS-1:0] shift_bits_next;
  logic [FIELD_W-1:0]   saved_address;
  logic [FIELD_W-1:0]   saved_command;
  logic                 data_hit;
  logic                 rpt_hit;
  logic                 out_valid;
  logic [FIELD_W-1:0]   out_address;
  logic [FIELD_W-1:0]   out_command;
  logic                 out_repeat;

  always_comb begin
    symbol_index_next = symbol_index;
    lead_ok_next = lead_ok;
    repeat_ok_next = repeat_ok;
    bits_ok_next = bits_ok;
    shift_bits_next = shift_bits;
    if (symbol_index < IDX_W'(MAX_SYMBOLS)) begin
      symbol_index_next = symbol_index + IDX_W'(1);
    end
    if (symbol_index == '0) begin
      lead_ok_next = hit.lead;
      repeat_ok_next = hit.rpt;
    end else if (symbol_index <= IDX_W'(DATA_BITS)) begin
      shift_bits_next = {hit.one, shift_bits[DATA_BITS-1:1]};
      if (!hit.one && !hit.zero) begin
        bits_ok_next = 1'b0;
      end
    end
    data_hit = sym.end_of_frame && (symbol_index_next == IDX_W'(DATA_FRAME_LEN))
            && lead_ok_next && bits_ok_next;
    rpt_hit = sym.end_of_frame && (symbol_index_next == IDX_W'(REPEAT_FRAME_LEN))
            && repeat_ok_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_index <= '0;
      lead_ok <= 1'b0;
      repeat_ok <= 1'b0;
      bits_ok <= 1'b1;
      shift_bits <= '0;
      saved_address <= '0;
      saved_command <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      if (step) begin
        if (sym.end_of_frame) begin
          symbol_index <= '0;
          lead_ok <= 1'b0;
          repeat_ok <= 1'b0;
          bits_ok <= 1'b1;
          shift_bits <= '0;
        end else begin
          symbol_index <= symbol_index_next;
          lead_ok <= lead_ok_next;
          repeat_ok <= repeat_ok_next;
          bits_ok <= bits_ok_next;
          shift_bits <= shift_bits_next;
        end
        if (data_hit) begin
          saved_address <= shift_bits_next[FIELD_W-1:0];
          saved_command <= shift_bits_next[DATA_BITS-1:FIELD_W];
        end
        if (data_hit || rpt_hit) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && data_hit) begin
      out_address <= shift_bits_next[FIELD_W-1:0];
      out_command <= shift_bits_next[DATA_BITS-1:FIELD_W];
      out_repeat <= 1'b0;
    end else if (step && rpt_hit) begin
      out_address <= saved_address;
      out_command <= saved_command;
      out_repeat <= 1'b1;
    end
  end

  assign res.valid = out_valid;
  assign res.ir_address = out_address;
  assign res.ir_command = out_command;
  assign res.is_repeat = out_repeat;

endmodule

`default_nettype wire

### rtl/core/nec_ir_frame_decoder_top.sv
// NEC IR frame decoder top level: configuration registers, symbol input
// register, matcher and frame tracker. Depends on necir_pkg, necir_if,
// necir_match and necir_frame.
`default_nettype none

// Each symbol request is taken into an input register, matched against the
// configured code durations and folded into the frame state when the frame
// tracker steps; a result, if the symbol ends a valid data or repeat frame,
// is loaded into the result register at that same edge and offered from
// there. The block takes one symbol per clock as long as the result register
// is empty or being drained, so the sustained rate is one symbol per cycle,
// set by the combinational match and update between the input and result
// registers. Configuration writes take effect the next cycle and are meant to
// happen while no frame is in progress.
module nec_ir_frame_decoder_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [necir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [necir_pkg::TICK_W-1:0]    cfg_data,
  necir_sym_if.sink                      sym,
  necir_res_if.source                    res
);
  import necir_pkg::*;

  cfg_t   cfg;
  sym_t   sym_reg;
  logic   sym_valid;
  logic   step;
  match_t hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_margin <= RST_MATCH_MARGIN;
      cfg.lead_mark <= RST_LEAD_MARK;
      cfg.lead_space <= RST_LEAD_SPACE;
      cfg.repeat_mark <= RST_REPEAT_MARK;
      cfg.repeat_space <= RST_REPEAT_SPACE;
      cfg.bit_mark <= RST_BIT_MARK;
      cfg.zero_space <= RST_ZERO_SPACE;
      cfg.one_space <= RST_ONE_SPACE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATCH_MARGIN: cfg.match_margin <= cfg_data[MARGIN_W-1:0];
        REG_LEAD_MARK:    cfg.lead_mark <= cfg_data;
        REG_LEAD_SPACE:   cfg.lead_space <= cfg_data;
        REG_REPEAT_MARK:  cfg.repeat_mark <= cfg_data;
        REG_REPEAT_SPACE: cfg.repeat_space <= cfg_data;
        REG_BIT_MARK:     cfg.bit_mark <= cfg_data;
        REG_ZERO_SPACE:   cfg.zero_space <= cfg_data;
        REG_ONE_SPACE:    cfg.one_space <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign step = sym_valid && (!res.valid || res.ready);
  assign sym.ready = !sym_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_valid <= 1'b0;
    end else if (sym.ready) begin
      sym_valid <= sym.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sym.valid && sym.ready) begin
      sym_reg.mark_ticks <= sym.mark_ticks;
      sym_reg.space_ticks <= sym.space_ticks;
      sym_reg.end_of_frame <= sym.end_of_frame;
    end
  end

  necir_match u_match (
    .cfg (cfg),
    .sym (sym_reg),
    .hit (hit)
  );

  necir_frame u_frame (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .sym  (sym_reg),
    .hit  (hit),
    .res  (res)
  );

endmodule

`default_nettype wire

### rtl/core/necir_checker.sv
// Port-level checker for the NEC IR frame decoder and its bind statement.
// Depends on necir_pkg and nec_ir_frame_decoder_top_macros.svh.
`default_nettype none

`include "nec_ir_frame_decoder_top_macros.svh"

module necir_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          sym_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [necir_pkg::FIELD_W-1:0] res_address,
  input logic [necir_pkg::FIELD_W-1:0] res_command,
  input logic                          res_repeat
);
  import necir_pkg::*;

  logic [FIELD_W-1:0] last_address;
  logic [FIELD_W-1:0] last_command;

  // Tracks the fields of the most recent delivered data frame result.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_address <= '0;
      last_command <= '0;
    end else if (res_valid && res_ready && !res_repeat) begin
      last_address <= res_address;
      last_command <= res_command;
    end
  end

  `NECIR_AST_NEXT_RST(a_reset_clears, rst, !res_valid)
  `NECIR_AST_SAME(a_ready_when_empty, !res_valid, sym_ready)
  `NECIR_AST_SAME(a_repeat_address, res_valid && res_repeat, res_address == last_address)
  `NECIR_AST_SAME(a_repeat_command, res_valid && res_repeat, res_command == last_command)
  `NECIR_AST_NEXT(a_result_holds, res_valid && !res_ready,
    res_valid && $stable(res_address) && $stable(res_command))

endmodule

bind nec_ir_frame_decoder_top necir_checker u_necir_checker (
  .clk         (clk),
  .rst         (rst),
  .sym_ready   (sym.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_address (res.ir_address),
  .res_command (res.ir_command),
  .res_repeat  (res.is_repeat)
);

`default_nettype wire

### verif/nec_ir_frame_decoder_checker.sv
`timescale 1ns / 1ps
// Checker for the NEC IR frame decoder: watches the register port and both
// channels, predicts each decoded frame and compares it. Depends on necir_pkg and necir_if.
module nec_ir_frame_decoder_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [necir_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [necir_pkg::TICK_W-1:0]    cfg_data,
  necir_sym_if                            sym,
  necir_res_if                            res,
  output int                              fail_count,
  output int                              pending
);
  import necir_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] address;
    logic [FIELD_W-1:0] command;
    logic               is_rep;
  } frame_result_t;

  cfg_t               regs;
  logic [IDX_W-1:0]   sym_count;
  logic               lead_hit;
  logic               rpt_hit;
  logic               bits_good;
  logic [31:0]        bit_shift;
  logic [FIELD_W-1:0] last_addr;
  logic [FIELD_W-1:0] last_cmd;
  frame_result_t      decoded_q[$];
  frame_result_t      want;
  int                 errors = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] decoder mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic in_window(input int unsigned dur, input int unsigned spec_v);
    int unsigned marg;
    marg = regs.match_margin;
    return (dur < spec_v + marg) && (dur + marg > spec_v);
  endfunction

  function automatic logic pair_hit(input int unsigned mk, input int unsigned sp,
                                    input int unsigned mk_spec, input int unsigned sp_spec);
    return in_window(mk, mk_spec) && in_window(sp, sp_spec);
  endfunction

  task automatic clear_frame();
    sym_count = '0;
    lead_hit = 1'b0;
    rpt_hit = 1'b0;
    bits_good = 1'b1;
    bit_shift = '0;
  endtask

  task automatic decode_symbol(input logic [TICK_W-1:0] mark, input logic [TICK_W-1:0] space,
                               input logic last);
    logic bit_v;
    if (sym_count == 0) begin
      lead_hit = pair_hit(mark, space, regs.lead_mark, regs.lead_space);
      rpt_hit = pair_hit(mark, space, regs.repeat_mark, regs.repeat_space);
    end else if (sym_count <= DATA_BITS) begin
      if (pair_hit(mark, space, regs.bit_mark, regs.one_space)) begin
        bit_v = 1'b1;
      end else if (pair_hit(mark, space, regs.bit_mark, regs.zero_space)) begin
        bit_v = 1'b0;
      end else begin
        bit_v = 1'b0;
        bits_good = 1'b0;
      end
      bit_shift = {bit_v, bit_shift[31:1]};
    end
    if (sym_count < MAX_SYMBOLS) begin
      sym_count = sym_count + 1'b1;
    end
    if (last) begin
      if (sym_count == DATA_FRAME_LEN && lead_hit && bits_good) begin
        last_addr = bit_shift[15:0];
        last_cmd = bit_shift[31:16];
        decoded_q.push_back('{address: last_addr, command: last_cmd, is_rep: 1'b0});
      end else if (sym_count == REPEAT_FRAME_LEN && rpt_hit) begin
        decoded_q.push_back('{address: last_addr, command: last_cmd, is_rep: 1'b1});
      end
      clear_frame();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs.match_margin = RST_MATCH_MARGIN;
      regs.lead_mark = RST_LEAD_MARK;
      regs.lead_space = RST_LEAD_SPACE;
      regs.repeat_mark = RST_REPEAT_MARK;
      regs.repeat_space = RST_REPEAT_SPACE;
      regs.bit_mark = RST_BIT_MARK;
      regs.zero_space = RST_ZERO_SPACE;
      regs.one_space = RST_ONE_SPACE;
      last_addr = '0;
      last_cmd = '0;
      clear_frame();
      decoded_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: addr %h cmd %h rep %b",
                                    res.ir_address, res.ir_command, res.is_repeat));
        end else begin
          want = decoded_q.pop_front();
          if (res.ir_address !== want.address) begin
            report_mismatch($sformatf("ir_address %h, predicted %h",
                                      res.ir_address, want.address));
          end
          if (res.ir_command !== want.command) begin
            report_mismatch($sformatf("ir_command %h, predicted %h",
                                      res.ir_command, want.command));
          end
          if (res.is_repeat !== want.is_rep) begin
            report_mismatch($sformatf("is_repeat %b, predicted %b",
                                      res.is_repeat, want.is_rep));
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MATCH_MARGIN: regs.match_margin = cfg_data[MARGIN_W-1:0];
          REG_LEAD_MARK:    regs.lead_mark = cfg_data;
          REG_LEAD_SPACE:   regs.lead_space = cfg_data;
          REG_REPEAT_MARK:  regs.repeat_mark = cfg_data;
          REG_REPEAT_SPACE: regs.repeat_space = cfg_data;
          REG_BIT_MARK:     regs.bit_mark = cfg_data;
          REG_ZERO_SPACE:   regs.zero_space = cfg_data;
          REG_ONE_SPACE:    regs.one_space = cfg_data;
          default: ;
        endcase
      end
      if (sym.valid && sym.ready) begin
        decode_symbol(sym.mark_ticks, sym.space_ticks, sym.end_of_frame);
      end
    end
    pending <= decoded_q.size();
    fail_count <= errors;
  end

endmodule

### verif/nec_ir_frame_decoder_top_test.sv
`timescale 1ns / 1ps
// Testbench top for the NEC IR frame decoder: drives symbol requests, register
// writes and result backpressure, and gives the verdict. Depends on necir_pkg,
// necir_if, nec_ir_frame_decoder_top and nec_ir_frame_decoder_checker.
module nec_ir_frame_decoder_top_test;
  import necir_pkg::*;

  localparam int TICK_MAX = (1 << TICK_W) - 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT = 4000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TICK_W-1:0]    cfg_data;
  int                   send_idle_pct = 0;
  int                   recv_stall_pct = 0;
  int                   accepted = 0;
  int                   quiet_cycles = 0;
  int                   fail_count;
  int                   pending;
  int                   spec [8];

  necir_sym_if sym();
  necir_res_if res();

  nec_ir_frame_decoder_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sym       (sym),
    .res       (res)
  );

  nec_ir_frame_decoder_checker decode_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sym        (sym),
    .res        (res),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (sym.valid && sym.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [TICK_W-1:0] clamp_ticks(input int v);
    if (v < 0) begin
      return '0;
    end
    if (v > TICK_MAX) begin
      return TICK_MAX;
    end
    return v[TICK_W-1:0];
  endfunction

  // A duration strictly inside the window, often on its edge; a random one if the window is empty.
  function automatic logic [TICK_W-1:0] pick_near(input int spec_v);
    int lo;
    int hi;
    lo = spec_v - spec[REG_MATCH_MARGIN] + 1;
    hi = spec_v + spec[REG_MATCH_MARGIN] - 1;
    if (lo < 0) lo = 0;
    if (hi > TICK_MAX) hi = TICK_MAX;
    if (lo > hi) begin
      return $urandom_range(TICK_MAX);
    end
    case ($urandom_range(9))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic logic [TICK_W-1:0] pick_noise(input int spec_v);
    case ($urandom_range(5))
      0: return '0;
      1: return TICK_MAX;
      2: return clamp_ticks(spec_v + spec[REG_MATCH_MARGIN]);
      3: return clamp_ticks(spec_v - spec[REG_MATCH_MARGIN]);
      default: return $urandom_range(TICK_MAX);
    endcase
  endfunction

  task automatic send_sym(input logic [TICK_W-1:0] mark, input logic [TICK_W-1:0] space,
                          input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      sym.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    sym.valid <= 1'b1;
    sym.mark_ticks <= mark;
    sym.space_ticks <= space;
    sym.end_of_frame <= last;
    do @(posedge clk); while (!sym.ready);
    accepted++;
  endtask

  task automatic send_bit(input logic bit_v, input logic spoil);
    int space_spec;
    space_spec = bit_v ? spec[REG_ONE_SPACE] : spec[REG_ZERO_SPACE];
    if (spoil) begin
      send_sym(pick_noise(spec[REG_BIT_MARK]), pick_noise(space_spec), 1'b0);
    end else begin
      send_sym(pick_near(spec[REG_BIT_MARK]), pick_near(space_spec), 1'b0);
    end
  endtask

  task automatic send_data_frame();
    int k;
    if ($urandom_range(7) == 0) begin
      send_sym(pick_noise(spec[REG_LEAD_MARK]), pick_noise(spec[REG_LEAD_SPACE]), 1'b0);
    end else begin
      send_sym(pick_near(spec[REG_LEAD_MARK]), pick_near(spec[REG_LEAD_SPACE]), 1'b0);
    end
    for (k = 0; k < DATA_BITS; k++) begin
      send_bit($urandom_range(1), $urandom_range(127) == 0);
    end
    send_sym(pick_noise(spec[REG_BIT_MARK]), $urandom_range(TICK_MAX), 1'b1);
  endtask

  task automatic send_repeat_frame();
    if ($urandom_range(7) == 0) begin
      send_sym(pick_noise(spec[REG_REPEAT_MARK]), pick_noise(spec[REG_REPEAT_SPACE]), 1'b0);
    end else begin
      send_sym(pick_near(spec[REG_REPEAT_MARK]), pick_near(spec[REG_REPEAT_SPACE]), 1'b0);
    end
    send_sym($urandom_range(TICK_MAX), $urandom_range(TICK_MAX), 1'b1);
  endtask

  // Frames of a wrong length, including ones long enough to saturate the count.
  task automatic send_odd_frame();
    int len;
    int k;
    case ($urandom_range(7))
      0: len = 1;
      1: len = 3;
      2: len = DATA_FRAME_LEN - 1;
      3: len = DATA_FRAME_LEN + 1;
      4: len = MAX_SYMBOLS;
      5: len = MAX_SYMBOLS + 1;
      6: len = $urandom_range(170, MAX_SYMBOLS + 2);
      default: len = $urandom_range(DATA_FRAME_LEN - 2, 4);
    endcase
    case ($urandom_range(3))
      0, 1: send_sym(pick_near(spec[REG_LEAD_MARK]), pick_near(spec[REG_LEAD_SPACE]), len == 1);
      2: send_sym(pick_near(spec[REG_REPEAT_MARK]), pick_near(spec[REG_REPEAT_SPACE]), len == 1);
      default: send_sym(pick_noise(spec[REG_LEAD_MARK]), pick_noise(spec[REG_BIT_MARK]), len == 1);
    endcase
    for (k = 1; k < len - 1; k++) begin
      send_bit($urandom_range(1), $urandom_range(15) == 0);
    end
    if (len > 1) begin
      send_sym(pick_noise(spec[REG_BIT_MARK]), pick_noise(spec[REG_ONE_SPACE]), 1'b1);
    end
  endtask

  task automatic send_noise();
    send_sym(pick_noise(spec[REG_BIT_MARK]), pick_noise(spec[REG_ZERO_SPACE]),
             $urandom_range(2) == 0);
  endtask

  task automatic drain();
    sym.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int n);
    int goal;
    int half;
    logic paused;
    goal = accepted + n;
    half = accepted + n / 2;
    paused = 1'b0;
    while (accepted < goal) begin
      if (!paused && accepted >= half) begin
        drain();
        paused = 1'b1;
      end
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: send_data_frame();
        9, 10, 11, 12, 13: send_repeat_frame();
        14, 15, 16, 17: send_odd_frame();
        default: send_noise();
      endcase
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[TICK_W-1:0];
    @(posedge clk);
  endtask

  task automatic load_setting();
    write_reg(REG_MATCH_MARGIN,
              ($urandom_range(31) << MARGIN_W) | spec[REG_MATCH_MARGIN]);
    write_reg(REG_LEAD_MARK, spec[REG_LEAD_MARK]);
    write_reg(REG_LEAD_SPACE, spec[REG_LEAD_SPACE]);
    write_reg(REG_REPEAT_MARK, spec[REG_REPEAT_MARK]);
    write_reg(REG_REPEAT_SPACE, spec[REG_REPEAT_SPACE]);
    write_reg(REG_BIT_MARK, spec[REG_BIT_MARK]);
    write_reg(REG_ZERO_SPACE, spec[REG_ZERO_SPACE]);
    write_reg(REG_ONE_SPACE, spec[REG_ONE_SPACE]);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic default_setting();
    spec[REG_MATCH_MARGIN] = RST_MATCH_MARGIN;
    spec[REG_LEAD_MARK] = RST_LEAD_MARK;
    spec[REG_LEAD_SPACE] = RST_LEAD_SPACE;
    spec[REG_REPEAT_MARK] = RST_REPEAT_MARK;
    spec[REG_REPEAT_SPACE] = RST_REPEAT_SPACE;
    spec[REG_BIT_MARK] = RST_BIT_MARK;
    spec[REG_ZERO_SPACE] = RST_ZERO_SPACE;
    spec[REG_ONE_SPACE] = RST_ONE_SPACE;
  endtask

  task automatic random_setting(input int margin_lo, input int margin_hi);
    spec[REG_MATCH_MARGIN] = $urandom_range(margin_hi, margin_lo);
    spec[REG_LEAD_MARK] = $urandom_range(TICK_MAX);
    spec[REG_LEAD_SPACE] = $urandom_range(TICK_MAX);
    spec[REG_REPEAT_MARK] = $urandom_range(TICK_MAX);
    spec[REG_REPEAT_SPACE] = $urandom_range(TICK_MAX);
    spec[REG_BIT_MARK] = $urandom_range(TICK_MAX);
    spec[REG_ZERO_SPACE] = $urandom_range(TICK_MAX);
    spec[REG_ONE_SPACE] = $urandom_range(TICK_MAX);
  endtask

  task automatic choose_setting(input int phase);
    case (phase)
      1: random_setting(20, 400);
      2: begin
        // The margin exceeds several spec values, so any short duration matches them.
        spec[REG_MATCH_MARGIN] = (1 << MARGIN_W) - 1;
        spec[REG_LEAD_MARK] = 20000;
        spec[REG_LEAD_SPACE] = 6000;
        spec[REG_REPEAT_MARK] = 20000;
        spec[REG_REPEAT_SPACE] = 3000;
        spec[REG_BIT_MARK] = 100;
        spec[REG_ZERO_SPACE] = 0;
        spec[REG_ONE_SPACE] = 2500;
      end
      3: begin
        random_setting(0, 0);
      end
      4: begin
        spec[REG_MATCH_MARGIN] = 1;
        spec[REG_LEAD_MARK] = TICK_MAX;
        spec[REG_LEAD_SPACE] = 0;
        spec[REG_REPEAT_MARK] = 0;
        spec[REG_REPEAT_SPACE] = TICK_MAX;
        spec[REG_BIT_MARK] = TICK_MAX;
        spec[REG_ZERO_SPACE] = 0;
        spec[REG_ONE_SPACE] = TICK_MAX;
      end
      5: begin
        // Zero and one share a space, so every good bit is ambiguous.
        random_setting(50, 300);
        spec[REG_ZERO_SPACE] = $urandom_range(5000, 1000);
        spec[REG_ONE_SPACE] = spec[REG_ZERO_SPACE];
      end
      6: random_setting(1, (1 << MARGIN_W) - 1);
      default: default_setting();
    endcase
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 60;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 60;
      end
      default: begin
        send_idle_pct = 24;
        recv_stall_pct = 24;
      end
    endcase
  endtask

  initial begin
    int phase;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_MATCH_MARGIN;
    cfg_data = '0;
    sym.valid = 1'b0;
    sym.mark_ticks = '0;
    sym.space_ticks = '0;
    sym.end_of_frame = 1'b0;
    default_setting();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(0);
    send_sym('0, '0, 1'b1);
    send_sym(TICK_MAX, TICK_MAX, 1'b1);
    // A repeat before any data frame gives the cleared saved values.
    send_sym(9000, 2250, 1'b0);
    send_sym(TICK_MAX, '0, 1'b1);
    send_sym(8801, 2449, 1'b0);
    send_sym('0, TICK_MAX, 1'b1);
    send_sym(9199, 2051, 1'b0);
    send_sym('0, '0, 1'b1);
    send_sym(8800, 2250, 1'b0);
    send_sym('0, '0, 1'b1);
    send_sym(9000, 2450, 1'b0);
    send_sym('0, '0, 1'b1);
    send_sym(9000, 4500, 1'b1);
    send_sym(9000, 2250, 1'b0);
    send_sym('0, '0, 1'b0);
    send_sym('0, '0, 1'b1);
    run_random(250);
    drain();

    for (phase = 1; phase <= 7; phase++) begin
      choose_setting(phase);
      load_setting();
      set_idling(phase % 4);
      run_random(phase == 3 ? 60 : 180);
      drain();
    end

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
